// ----- rtl/ogw_pkg.sv -----
`timescale 1ns / 1ps

package ogw_pkg;

    // pixels per glyph byte, one lane each
    localparam int LANES  = 8;
    localparam int LIDX_W = 3;
    localparam int COL_W  = 4;

    // register reset values
    localparam logic [31:0] FRAME_BASE_RST  = 32'd0;
    localparam logic [12:0] FRAME_WIDTH_RST = 13'd640;
    localparam logic [24:0] LUMA_SIZE_RST   = 25'd307200;
    localparam logic [23:0] FONT_COLOR_RST  = 24'hFF8080;
    localparam logic [23:0] BACK_COLOR_RST  = 24'h108080;
    localparam logic        BACK_ENABLE_RST = 1'b0;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_FRAME_BASE  = 3'd0,
        REG_FRAME_WIDTH = 3'd1,
        REG_LUMA_SIZE   = 3'd2,
        REG_FONT_COLOR  = 3'd3,
        REG_BACK_COLOR  = 3'd4,
        REG_BACK_ENABLE = 3'd5
    } cfg_reg_t;

    // frame buffer plane of a write
    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } plane_t;

    // per-item bases and colours shared by all lanes
    typedef struct packed {
        logic [31:0] y_base;
        logic [31:0] u_base;
        logic [31:0] v_base;
        logic [23:0] font_color;
        logic [23:0] back_color;
        logic        back_enable;
    } lane_base_t;

    // what one lane found for its pixel
    typedef struct packed {
        logic        draw;
        logic [31:0] y_addr;
        logic [31:0] u_addr;
        logic [31:0] v_addr;
        logic [7:0]  y_data;
        logic [7:0]  u_data;
        logic [7:0]  v_data;
    } lane_word_t;

    // first stage: products and decoded position
    typedef struct packed {
        logic [7:0]  glyph_byte;
        logic        col0;
        logic        row_even;
        logic        skip;
        logic [11:0] char_x;
        logic [24:0] cy_w;
        logic [17:0] row_w;
    } s1_t;

    // second stage: plane bases
    typedef struct packed {
        logic [7:0]  glyph_byte;
        logic        col0;
        logic        row_even;
        logic        skip;
        logic [31:0] y_base;
        logic [31:0] u_base;
        logic [31:0] v_base;
    } s2_t;

endpackage

// ----- rtl/ogw_lane.sv -----
`timescale 1ns / 1ps

module ogw_lane (
    input  ogw_pkg::lane_base_t          base,
    input  logic                         pix_on,
    input  logic [ogw_pkg::COL_W-1:0]    col,
    output ogw_pkg::lane_word_t          word
);
    import ogw_pkg::*;

    logic [23:0] color;
    logic [COL_W-2:0] col_half;

    // colour choice: font on a set bit, background only when enabled
    assign color    = pix_on ? base.font_color : base.back_color;
    assign col_half = col[COL_W-1:1];

    // draw flag, plus pixel addresses and data in the three planes
    always_comb begin
        word.draw   = pix_on | base.back_enable;
        word.y_addr = base.y_base + 32'(col);
        word.u_addr = base.u_base + 32'(col_half);
        word.v_addr = base.v_base + 32'(col_half);
        word.y_data = color[23:16];
        word.u_data = color[15:8];
        word.v_data = color[7:0];
    end

endmodule

// ----- rtl/ogw_merge.sv -----
`timescale 1ns / 1ps

module ogw_merge (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  ogw_pkg::lane_word_t [ogw_pkg::LANES-1:0]   in_lanes,
    input  logic [ogw_pkg::LANES-1:0]                  in_mask,
    input  logic                                       in_chroma,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [31:0]                                m_write_address,
    output logic [7:0]                                 m_write_data,
    output logic [1:0]                                 m_plane,
    output logic                                       m_last
);
    import ogw_pkg::*;

    lane_word_t [LANES-1:0] lanes_reg, lanes_next;
    logic [LANES-1:0]       mask_reg, mask_next;
    logic                   chroma_reg, chroma_next;
    logic                   bund_valid_reg, bund_valid_next;
    plane_t                 phase_reg, phase_next;

    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            addr_reg, addr_next;
    logic [7:0]             data_reg, data_next;
    plane_t                 plane_reg, plane_next;
    logic                   last_reg, last_next;

    logic [LIDX_W-1:0]      cur_idx;
    lane_word_t             cur;
    logic [LANES-1:0]       mask_left;
    logic                   pix_done;
    logic                   word_last;
    logic                   out_free;
    logic                   emit;
    logic [31:0]            sel_addr;
    logic [7:0]             sel_data;

    // leftmost pixel still to be written
    always_comb begin
        cur_idx = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                cur_idx = LIDX_W'(k);
            end
        end
    end

    assign cur       = lanes_reg[cur_idx];
    assign mask_left = mask_reg & ~(LANES'(1) << cur_idx);
    assign pix_done  = (phase_reg == PLANE_V) || ((phase_reg == PLANE_Y) && !chroma_reg);
    assign word_last = pix_done && (mask_left == '0);
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = bund_valid_reg && out_free;
    assign in_ready  = !bund_valid_reg || (emit && word_last);

    // component of the current pixel
    always_comb begin
        unique case (phase_reg)
            PLANE_Y: begin
                sel_addr = cur.y_addr;
                sel_data = cur.y_data;
            end
            PLANE_U: begin
                sel_addr = cur.u_addr;
                sel_data = cur.u_data;
            end
            PLANE_V: begin
                sel_addr = cur.v_addr;
                sel_data = cur.v_data;
            end
            default: begin
                sel_addr = cur.y_addr;
                sel_data = cur.y_data;
            end
        endcase
    end

    // bundle walk and output register
    always_comb begin
        lanes_next      = lanes_reg;
        mask_next       = mask_reg;
        chroma_next     = chroma_reg;
        bund_valid_next = bund_valid_reg;
        phase_next      = phase_reg;
        m_valid_next    = m_valid_reg;
        addr_next       = addr_reg;
        data_next       = data_reg;
        plane_next      = plane_reg;
        last_next       = last_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            addr_next    = sel_addr;
            data_next    = sel_data;
            plane_next   = phase_reg;
            last_next    = word_last;
            if (pix_done) begin
                mask_next  = mask_left;
                phase_next = PLANE_Y;
            end else begin
                phase_next = (phase_reg == PLANE_Y) ? PLANE_U : PLANE_V;
            end
            if (word_last) begin
                bund_valid_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // an item with nothing to paint is taken and dropped here
        if (in_valid && in_ready) begin
            lanes_next      = in_lanes;
            mask_next       = in_mask;
            chroma_next     = in_chroma;
            phase_next      = PLANE_Y;
            bund_valid_next = |in_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bund_valid_reg <= 1'b0;
            mask_reg       <= '0;
            phase_reg      <= PLANE_Y;
            m_valid_reg    <= 1'b0;
        end else begin
            bund_valid_reg <= bund_valid_next;
            mask_reg       <= mask_next;
            phase_reg      <= phase_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lanes_reg  <= lanes_next;
        chroma_reg <= chroma_next;
        addr_reg   <= addr_next;
        data_reg   <= data_next;
        plane_reg  <= plane_next;
        last_reg   <= last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_write_address = addr_reg;
    assign m_write_data    = data_reg;
    assign m_plane         = 2'(plane_reg);
    assign m_last          = last_reg;

    // a held bundle always has a pixel left
    a_bund_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        bund_valid_reg |-> (mask_reg != '0))
        else $error("bundle held with no pixel left");

    // chroma phases only on even glyph rows
    a_chroma_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (bund_valid_reg && (phase_reg != PLANE_Y)) |-> chroma_reg)
        else $error("chroma phase on odd row");

    // finishing a pixel mid-bundle drops exactly one lane
    a_pixel_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && pix_done && !word_last) |=>
            ($countones(mask_reg) == $past($countones(mask_reg)) - 1))
        else $error("pixel retire lost a lane");

    // a word marked last ends the bundle
    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && word_last) |-> in_ready)
        else $error("last word without bundle release");

endmodule

// ----- rtl/osd_glyph_yuv420_writer.sv -----
`timescale 1ns / 1ps
// channel   | direction | handshake            | word
// s_        | in        | s_valid / s_ready    | glyph byte, byte index, wide flag, char origin
// m_        | out       | m_valid / m_ready    | write address, data, plane, last
// cfg_      | in        | cfg_we (no wait)     | register index, write data
//
// one write leaves per cycle while m_ready is not held low; an item gives one write
// per painted pixel on odd glyph rows and three per painted pixel on even rows, all
// from the output serialiser in the merge stage; an item that paints nothing gives no
// write. first write is registered after stage one, stage two and the merge bundle register.
// reset (aresetn, synchronous) empties the pipeline and restores register defaults.
// a stalled m_ready backs up through the stages to s_ready; no word is dropped.

module osd_glyph_yuv420_writer #(
    parameter int GLYPH_HEIGHT = 16,
    parameter int GLYPH_BYTES  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_glyph_byte,
    input  logic [4:0]  s_byte_index,
    input  logic        s_wide_glyph,
    input  logic [11:0] s_char_x,
    input  logic [11:0] s_char_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_write_address,
    output logic [7:0]  m_write_data,
    output logic [1:0]  m_plane,
    output logic        m_last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import ogw_pkg::*;

    localparam logic [31:0] GlyphHeightW = 32'(GLYPH_HEIGHT);
    localparam logic [31:0] GlyphBytesW  = 32'(GLYPH_BYTES);

    logic [31:0] frame_base_reg, frame_base_next;
    logic [12:0] frame_width_reg, frame_width_next;
    logic [24:0] luma_size_reg, luma_size_next;
    logic [23:0] font_color_reg, font_color_next;
    logic [23:0] back_color_reg, back_color_next;
    logic        back_enable_reg, back_enable_next;

    s1_t  s1_reg, s1_next;
    logic s1_valid_reg, s1_valid_next;
    s2_t  s2_reg, s2_next;
    logic s2_valid_reg, s2_valid_next;

    logic s1_ready, s2_ready, merge_ready;
    logic [4:0] row;

    lane_base_t                lane_base;
    lane_word_t [LANES-1:0]    lane_words;
    logic [LANES-1:0]          lane_mask;

    // register writes
    always_comb begin
        frame_base_next  = frame_base_reg;
        frame_width_next = frame_width_reg;
        luma_size_next   = luma_size_reg;
        font_color_next  = font_color_reg;
        back_color_next  = back_color_reg;
        back_enable_next = back_enable_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_BASE:  frame_base_next  = cfg_wdata;
                REG_FRAME_WIDTH: frame_width_next = cfg_wdata[12:0];
                REG_LUMA_SIZE:   luma_size_next   = cfg_wdata[24:0];
                REG_FONT_COLOR:  font_color_next  = cfg_wdata[23:0];
                REG_BACK_COLOR:  back_color_next  = cfg_wdata[23:0];
                REG_BACK_ENABLE: back_enable_next = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg  <= FRAME_BASE_RST;
            frame_width_reg <= FRAME_WIDTH_RST;
            luma_size_reg   <= LUMA_SIZE_RST;
            font_color_reg  <= FONT_COLOR_RST;
            back_color_reg  <= BACK_COLOR_RST;
            back_enable_reg <= BACK_ENABLE_RST;
        end else begin
            frame_base_reg  <= frame_base_next;
            frame_width_reg <= frame_width_next;
            luma_size_reg   <= luma_size_next;
            font_color_reg  <= font_color_next;
            back_color_reg  <= back_color_next;
            back_enable_reg <= back_enable_next;
        end
    end

    // pipeline flow
    assign s2_ready = !s2_valid_reg || merge_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;

    // stage one: glyph row, range check and the two products
    assign row = s_wide_glyph ? {1'b0, s_byte_index[4:1]} : s_byte_index;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (s1_ready) begin
            s1_valid_next      = s_valid;
            s1_next.glyph_byte = s_glyph_byte;
            s1_next.col0       = s_wide_glyph & s_byte_index[0];
            s1_next.row_even   = ~row[0];
            s1_next.skip       = (32'(s_byte_index) >= GlyphBytesW) ||
                                 (32'(row) >= GlyphHeightW);
            s1_next.char_x     = s_char_x;
            s1_next.cy_w       = 25'(s_char_y) * 25'(frame_width_reg);
            s1_next.row_w      = 18'(row) * 18'(frame_width_reg);
        end
    end

    // stage two: plane bases, v plane starts at luma + luma/4
    always_comb begin
        s2_valid_next = s2_valid_reg;
        s2_next       = s2_reg;
        if (s2_ready) begin
            s2_valid_next      = s1_valid_reg;
            s2_next.glyph_byte = s1_reg.glyph_byte;
            s2_next.col0       = s1_reg.col0;
            s2_next.row_even   = s1_reg.row_even;
            s2_next.skip       = s1_reg.skip;
            s2_next.y_base     = frame_base_reg + 32'(s1_reg.cy_w) + 32'(s1_reg.char_x)
                                 + 32'(s1_reg.row_w);
            s2_next.u_base     = frame_base_reg + 32'(luma_size_reg)
                                 + 32'(s1_reg.cy_w[24:2]) + 32'(s1_reg.char_x[11:1])
                                 + 32'(s1_reg.row_w[17:2]);
            s2_next.v_base     = frame_base_reg + 32'(luma_size_reg)
                                 + 32'(luma_size_reg[24:2])
                                 + 32'(s1_reg.cy_w[24:2]) + 32'(s1_reg.char_x[11:1])
                                 + 32'(s1_reg.row_w[17:2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    // pixel lanes
    always_comb begin
        lane_base.y_base      = s2_reg.y_base;
        lane_base.u_base      = s2_reg.u_base;
        lane_base.v_base      = s2_reg.v_base;
        lane_base.font_color  = font_color_reg;
        lane_base.back_color  = back_color_reg;
        lane_base.back_enable = back_enable_reg;
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        ogw_lane u_lane (
            .base   (lane_base),
            .pix_on (s2_reg.glyph_byte[LANES-1-k]),
            .col    ({s2_reg.col0, LIDX_W'(k)}),
            .word   (lane_words[k])
        );
        assign lane_mask[k] = lane_words[k].draw & ~s2_reg.skip;
    end

    // merge and serialise
    ogw_merge u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s2_valid_reg),
        .in_ready        (merge_ready),
        .in_lanes        (lane_words),
        .in_mask         (lane_mask),
        .in_chroma       (s2_reg.row_even),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data),
        .m_plane         (m_plane),
        .m_last          (m_last)
    );

endmodule
